// ----- design/infix_expression_evaluator_macros.svh -----
// Assertion macros used by the top level of the infix expression evaluator.
`ifndef INFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define INFIX_EXPRESSION_EVALUATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IEE_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("iee check failed");

// The consequent must hold in the cycle after the antecedent.
`define IEE_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("iee check failed");

`endif

// ----- design/iee_pkg.sv -----
// Types and constants shared by the infix expression evaluator.
`default_nettype none
package iee_pkg;

  localparam int OP_DEPTH  = 64;
  localparam int VAL_DEPTH = 64;
  localparam int OCW = $clog2(OP_DEPTH + 1);
  localparam int OAW = $clog2(OP_DEPTH);
  localparam int VCW = $clog2(VAL_DEPTH + 1);
  localparam int VAW = $clog2(VAL_DEPTH);
  localparam int DW  = 32;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_LPAR = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    CL_DIGIT = 3'd0,
    CL_ADD   = 3'd1,
    CL_SUB   = 3'd2,
    CL_MUL   = 3'd3,
    CL_DIV   = 3'd4,
    CL_LPAR  = 3'd5,
    CL_RPAR  = 3'd6,
    CL_BAD   = 3'd7
  } cls_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DIV0   = 2'd1,
    ST_STACK  = 2'd2,
    ST_BADCHR = 2'd3
  } st_e;

  typedef struct packed {
    cls_e       cls;
    logic [3:0] digit;
    logic       last;
  } itm_t;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] a;
    logic [DW-1:0] b;
  } div_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [DW-1:0] q;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- design/iee_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module iee_ram #(
  parameter int W = 32,
  parameter int D = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [$clog2(D)-1:0] waddr_i,
  input  wire logic [W-1:0]         wdata_i,
  input  wire logic                 re_i,
  input  wire logic [$clog2(D)-1:0] raddr_i,
  output logic      [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- design/iee_front.sv -----
// Front end: classifies characters and queues them for the back end.
`default_nettype none
module iee_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire logic [7:0]    char_code_i,
  input  wire logic          end_of_expr_i,
  output logic               itm_valid_o,
  output iee_pkg::itm_t      itm_o,
  input  wire logic          itm_pop_i
);

  iee_pkg::itm_t itm_q [2];
  iee_pkg::itm_t new_itm;
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q, cnt_d;
  logic          wr, rd;

  always_comb begin
    new_itm.digit = char_code_i[3:0];
    new_itm.last  = end_of_expr_i;
    if (char_code_i >= iee_pkg::CH_ZERO && char_code_i <= iee_pkg::CH_NINE) begin
      new_itm.cls = iee_pkg::CL_DIGIT;
    end else begin
      case (char_code_i)
        iee_pkg::CH_PLUS:  new_itm.cls = iee_pkg::CL_ADD;
        iee_pkg::CH_MINUS: new_itm.cls = iee_pkg::CL_SUB;
        iee_pkg::CH_STAR:  new_itm.cls = iee_pkg::CL_MUL;
        iee_pkg::CH_SLASH: new_itm.cls = iee_pkg::CL_DIV;
        iee_pkg::CH_LPAR:  new_itm.cls = iee_pkg::CL_LPAR;
        iee_pkg::CH_RPAR:  new_itm.cls = iee_pkg::CL_RPAR;
        default:           new_itm.cls = iee_pkg::CL_BAD;
      endcase
    end
  end

  assign full        = (cnt_q == 2'd2);
  assign itm_valid_o = (cnt_q != 2'd0);
  assign itm_o       = itm_q[rp_q];
  assign wr          = push && !full;
  assign rd          = itm_pop_i && itm_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (wr && !rd) begin
      cnt_d = cnt_q + 2'd1;
    end else if (rd && !wr) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (wr) begin
        wp_q <= !wp_q;
      end
      if (rd) begin
        rp_q <= !rp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      itm_q[wp_q] <= new_itm;
    end
  end

endmodule
`default_nettype wire

// ----- design/iee_div.sv -----
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module iee_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  iee_pkg::div_req_t      req_i,
  output iee_pkg::div_rsp_t      rsp_o
);

  logic                   busy_q, done_q;
  logic [4:0]             cnt_q;
  logic [iee_pkg::DW-1:0] rem_q, quo_q, mb_q;
  logic                   neg_q;
  logic [iee_pkg::DW:0]   sh, diff;
  logic                   ge;

  assign sh   = {rem_q, quo_q[iee_pkg::DW-1]};
  assign diff = sh - {1'b0, mb_q};
  assign ge   = (sh >= {1'b0, mb_q});

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.q    = neg_q ? (~quo_q + 1'b1) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.a[iee_pkg::DW-1] ? (~req_i.a + 1'b1) : req_i.a;
      mb_q  <= req_i.b[iee_pkg::DW-1] ? (~req_i.b + 1'b1) : req_i.b;
      neg_q <= req_i.a[iee_pkg::DW-1] ^ req_i.b[iee_pkg::DW-1];
    end else if (busy_q) begin
      rem_q <= ge ? diff[iee_pkg::DW-1:0] : sh[iee_pkg::DW-1:0];
      quo_q <= {quo_q[iee_pkg::DW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// ----- design/iee_back.sv -----
// Back end: operator and value stacks, reduction sequencer and result register.
`default_nettype none
module iee_back (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    itm_valid_i,
  input  iee_pkg::itm_t                itm_i,
  output logic                         itm_pop_o,
  output iee_pkg::div_req_t            div_req_o,
  input  iee_pkg::div_rsp_t            div_rsp_i,
  output logic                         empty,
  input  wire logic                    pop,
  output logic signed [31:0]           value_o,
  output logic        [1:0]            status_o
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CHAR  = 11'b00000000010,
    S_OP    = 11'b00000000100,
    S_DONE  = 11'b00000001000,
    S_END   = 11'b00000010000,
    S_DRAIN = 11'b00000100000,
    S_RD    = 11'b00001000000,
    S_EX    = 11'b00010000000,
    S_DIV   = 11'b00100000000,
    S_WB    = 11'b01000000000,
    S_FIN   = 11'b10000000000
  } state_e;

  localparam int DW  = iee_pkg::DW;
  localparam int OCW = iee_pkg::OCW;
  localparam int OAW = iee_pkg::OAW;
  localparam int VCW = iee_pkg::VCW;
  localparam int VAW = iee_pkg::VAW;

  state_e         state_q, state_d, ret_q, ret_d;
  iee_pkg::cls_e  cls_q, cls_d;
  logic [3:0]     dig_q, dig_d;
  logic           last_q, last_d;
  logic [DW-1:0]  acc_q, acc_d;
  logic           innum_q, innum_d;
  iee_pkg::st_e   err_q, err_d;
  logic [DW-1:0]  tos_q, tos_d, nos_q, nos_d, r_q, r_d;
  logic [VCW-1:0] vcnt_q, vcnt_d;
  logic [OCW-1:0] ocnt_q, ocnt_d;
  iee_pkg::op_e   top_q, top_d, opr_q, opr_d, new_op;
  logic           red_q, red_d;
  logic           ovld_q, ovld_d;
  logic [DW-1:0]  oval_q, oval_d;
  iee_pkg::st_e   ost_q, ost_d;

  logic           vwe, vre, owe, ore;
  logic [VCW-1:0] vcnt_m2, vcnt_m3;
  logic [OCW-1:0] ocnt_m1, ocnt_m2;
  logic [DW-1:0]  vwdata, vrd;
  logic [2:0]     ord;
  logic           val_full, op_full;

  assign vcnt_m2  = vcnt_q - VCW'(2);
  assign vcnt_m3  = vcnt_q - VCW'(3);
  assign ocnt_m1  = ocnt_q - OCW'(1);
  assign ocnt_m2  = ocnt_q - OCW'(2);
  assign val_full = (vcnt_q >= VCW'(iee_pkg::VAL_DEPTH));
  assign op_full  = (ocnt_q >= OCW'(iee_pkg::OP_DEPTH));
  assign vwdata   = nos_q;

  assign empty    = !ovld_q;
  assign value_o  = oval_q;
  assign status_o = ost_q;

  iee_ram #(.W(DW), .D(iee_pkg::VAL_DEPTH)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (vwe),
    .waddr_i (vcnt_m2[VAW-1:0]),
    .wdata_i (vwdata),
    .re_i    (vre),
    .raddr_i (vcnt_m3[VAW-1:0]),
    .rdata_o (vrd)
  );

  iee_ram #(.W(3), .D(iee_pkg::OP_DEPTH)) u_op_ram (
    .clk_i   (clk_i),
    .we_i    (owe),
    .waddr_i (ocnt_m1[OAW-1:0]),
    .wdata_i (top_q),
    .re_i    (ore),
    .raddr_i (ocnt_m2[OAW-1:0]),
    .rdata_o (ord)
  );

  always_comb begin
    case (cls_q)
      iee_pkg::CL_ADD: new_op = iee_pkg::OP_ADD;
      iee_pkg::CL_SUB: new_op = iee_pkg::OP_SUB;
      iee_pkg::CL_MUL: new_op = iee_pkg::OP_MUL;
      iee_pkg::CL_DIV: new_op = iee_pkg::OP_DIV;
      default:         new_op = iee_pkg::OP_LPAR;
    endcase
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    cls_d   = cls_q;
    dig_d   = dig_q;
    last_d  = last_q;
    acc_d   = acc_q;
    innum_d = innum_q;
    err_d   = err_q;
    tos_d   = tos_q;
    nos_d   = nos_q;
    r_d     = r_q;
    vcnt_d  = vcnt_q;
    ocnt_d  = ocnt_q;
    top_d   = top_q;
    opr_d   = opr_q;
    red_d   = red_q;
    ovld_d  = ovld_q && !pop;
    oval_d  = oval_q;
    ost_d   = ost_q;
    vwe     = 1'b0;
    vre     = 1'b0;
    owe     = 1'b0;
    ore     = 1'b0;
    itm_pop_o = 1'b0;
    div_req_o.start = 1'b0;
    div_req_o.a     = nos_q;
    div_req_o.b     = tos_q;

    case (state_q)
      S_IDLE: begin
        itm_pop_o = itm_valid_i;
        if (itm_valid_i) begin
          cls_d   = itm_i.cls;
          dig_d   = itm_i.digit;
          last_d  = itm_i.last;
          state_d = S_CHAR;
        end
      end
      S_CHAR: begin
        if (err_q != iee_pkg::ST_OK) begin
          state_d = last_q ? S_FIN : S_IDLE;
        end else if (cls_q == iee_pkg::CL_DIGIT) begin
          acc_d   = {acc_q[DW-4:0], 3'b000} + {acc_q[DW-2:0], 1'b0} + DW'(dig_q);
          innum_d = 1'b1;
          state_d = last_q ? S_END : S_IDLE;
        end else begin
          if (innum_q) begin
            if (val_full) begin
              err_d = iee_pkg::ST_STACK;
            end else begin
              vwe    = (vcnt_q >= VCW'(2));
              nos_d  = tos_q;
              tos_d  = acc_q;
              vcnt_d = vcnt_q + VCW'(1);
            end
            innum_d = 1'b0;
            acc_d   = '0;
          end
          state_d = S_OP;
        end
      end
      S_OP: begin
        state_d = S_DONE;
        if (err_q == iee_pkg::ST_OK) begin
          case (cls_q)
            iee_pkg::CL_ADD, iee_pkg::CL_SUB, iee_pkg::CL_MUL, iee_pkg::CL_DIV,
            iee_pkg::CL_LPAR: begin
              if ((cls_q == iee_pkg::CL_ADD || cls_q == iee_pkg::CL_SUB) &&
                  ocnt_q != '0 && top_q != iee_pkg::OP_LPAR) begin
                red_d   = 1'b1;
                ret_d   = S_OP;
                state_d = S_RD;
              end else if ((cls_q == iee_pkg::CL_MUL || cls_q == iee_pkg::CL_DIV) &&
                           ocnt_q != '0 &&
                           (top_q == iee_pkg::OP_MUL || top_q == iee_pkg::OP_DIV)) begin
                red_d   = 1'b1;
                ret_d   = S_OP;
                state_d = S_RD;
              end else if (op_full) begin
                err_d = iee_pkg::ST_STACK;
              end else begin
                owe    = (ocnt_q != '0);
                top_d  = new_op;
                ocnt_d = ocnt_q + OCW'(1);
              end
            end
            iee_pkg::CL_RPAR: begin
              if (ocnt_q == '0) begin
                err_d = iee_pkg::ST_STACK;
              end else if (top_q == iee_pkg::OP_LPAR) begin
                red_d   = 1'b0;
                ret_d   = S_DONE;
                state_d = S_RD;
              end else begin
                red_d   = 1'b1;
                ret_d   = S_OP;
                state_d = S_RD;
              end
            end
            iee_pkg::CL_BAD: begin
              err_d = iee_pkg::ST_BADCHR;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_DONE: begin
        state_d = last_q ? S_END : S_IDLE;
      end
      S_END: begin
        if (err_q != iee_pkg::ST_OK) begin
          state_d = S_FIN;
        end else begin
          if (innum_q) begin
            if (val_full) begin
              err_d = iee_pkg::ST_STACK;
            end else begin
              vwe    = (vcnt_q >= VCW'(2));
              nos_d  = tos_q;
              tos_d  = acc_q;
              vcnt_d = vcnt_q + VCW'(1);
            end
            innum_d = 1'b0;
            acc_d   = '0;
          end
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_FIN;
        if (err_q == iee_pkg::ST_OK) begin
          if (ocnt_q != '0) begin
            if (top_q == iee_pkg::OP_LPAR) begin
              err_d = iee_pkg::ST_STACK;
            end else begin
              red_d   = 1'b1;
              ret_d   = S_DRAIN;
              state_d = S_RD;
            end
          end else if (vcnt_q == '0) begin
            err_d = iee_pkg::ST_STACK;
          end
        end
      end
      S_RD: begin
        ore     = 1'b1;
        vre     = 1'b1;
        opr_d   = top_q;
        ocnt_d  = ocnt_m1;
        state_d = S_EX;
      end
      S_EX: begin
        top_d = iee_pkg::op_e'(ord);
        if (!red_q) begin
          state_d = ret_q;
        end else if (vcnt_q < VCW'(2)) begin
          err_d   = iee_pkg::ST_STACK;
          state_d = ret_q;
        end else begin
          state_d = S_WB;
          case (opr_q)
            iee_pkg::OP_ADD: r_d = nos_q + tos_q;
            iee_pkg::OP_SUB: r_d = nos_q - tos_q;
            iee_pkg::OP_MUL: r_d = nos_q * tos_q;
            default: begin
              if (tos_q == '0) begin
                err_d = iee_pkg::ST_DIV0;
                r_d   = '0;
              end else begin
                div_req_o.start = 1'b1;
                state_d         = S_DIV;
              end
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_rsp_i.done) begin
          r_d     = div_rsp_i.q;
          state_d = S_WB;
        end
      end
      S_WB: begin
        tos_d   = r_q;
        nos_d   = vrd;
        vcnt_d  = vcnt_q - VCW'(1);
        state_d = ret_q;
      end
      S_FIN: begin
        if (!ovld_q || pop) begin
          ovld_d  = 1'b1;
          oval_d  = (err_q == iee_pkg::ST_OK) ? tos_q : '0;
          ost_d   = err_q;
          vcnt_d  = '0;
          ocnt_d  = '0;
          acc_d   = '0;
          innum_d = 1'b0;
          err_d   = iee_pkg::ST_OK;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      acc_q   <= '0;
      innum_q <= 1'b0;
      err_q   <= iee_pkg::ST_OK;
      vcnt_q  <= '0;
      ocnt_q  <= '0;
      red_q   <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      acc_q   <= acc_d;
      innum_q <= innum_d;
      err_q   <= err_d;
      vcnt_q  <= vcnt_d;
      ocnt_q  <= ocnt_d;
      red_q   <= red_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q  <= cls_d;
    dig_q  <= dig_d;
    last_q <= last_d;
    tos_q  <= tos_d;
    nos_q  <= nos_d;
    r_q    <= r_d;
    top_q  <= top_d;
    opr_q  <= opr_d;
    oval_q <= oval_d;
    ost_q  <= ost_d;
  end

endmodule
`default_nettype wire

// ----- design/infix_expression_evaluator.sv -----
// Top level of the infix expression evaluator.
// The block takes one ASCII character per item and, on the item marked as the
// end of the expression, delivers one result with a 32-bit value and a status
// code. A two-item front queue accepts characters while the back end works.
// In the back end a digit passes through S_IDLE and S_CHAR and an operator
// also through S_OP and S_DONE; each reduction that walks the stacks adds
// S_RD, S_EX and S_WB (the stack RAMs have a registered read port), a ')'
// that meets its '(' adds S_RD and S_EX, and a division waits in S_DIV for
// the one-bit-per-cycle divider. The end of an expression runs the remaining
// reductions, and the final result waits in an output register until popped.
`default_nettype none
`include "infix_expression_evaluator_macros.svh"
module infix_expression_evaluator (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [7:0]         char_code_i,
  input  wire logic               end_of_expr_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [31:0]      value_o,
  output logic        [1:0]       status_o
);

  iee_pkg::itm_t     itm;
  logic              itm_valid, itm_pop;
  iee_pkg::div_req_t dreq;
  iee_pkg::div_rsp_t drsp;

  iee_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .char_code_i   (char_code_i),
    .end_of_expr_i (end_of_expr_i),
    .itm_valid_o   (itm_valid),
    .itm_o         (itm),
    .itm_pop_i     (itm_pop)
  );

  iee_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  iee_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .itm_valid_i (itm_valid),
    .itm_i       (itm),
    .itm_pop_o   (itm_pop),
    .div_req_o   (dreq),
    .div_rsp_i   (drsp),
    .empty       (empty),
    .pop         (pop),
    .value_o     (value_o),
    .status_o    (status_o)
  );

  `IEE_IMPLIES(a_pop_has_item, itm_pop, itm_valid)
  `IEE_IMPLIES(a_err_value_zero, !empty && (status_o != iee_pkg::ST_OK), value_o == '0)
  `IEE_NEXT(a_div_runs, dreq.start, drsp.busy)

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// Testbench for the infix expression evaluator: directed and random expressions checked against a predictor.
module tb;
  import iee_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [7:0] char_code_i = 8'd0;
  logic end_of_expr_i = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic signed [31:0] value_o;
  logic [1:0] status_o;

  infix_expression_evaluator dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .char_code_i(char_code_i), .end_of_expr_i(end_of_expr_i),
    .empty(empty), .pop(pop), .value_o(value_o), .status_o(status_o)
  );

  always #10 clk_i = ~clk_i;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic [31:0] value;
    st_e         status;
  } eval_result_t;

  char_item_t   pending_chars[$];
  eval_result_t expected_results[$];
  int  errors = 0;
  bit  drain_wait = 0;
  int  hold_pop = 0;

  op_e         ops[OP_DEPTH];
  int          n_ops;
  logic [31:0] vals[VAL_DEPTH];
  int          n_vals;
  logic [31:0] acc;
  bit          acc_live;
  st_e         err;

  function automatic void clear_eval();
    n_ops = 0;
    n_vals = 0;
    acc = '0;
    acc_live = 0;
    err = ST_OK;
  endfunction

  function automatic void raise(st_e code);
    if (err == ST_OK) err = code;
  endfunction

  function automatic void push_value(logic [31:0] v);
    if (n_vals >= VAL_DEPTH) raise(ST_STACK);
    else begin
      vals[n_vals] = v;
      n_vals++;
    end
  endfunction

  function automatic void push_operator(op_e o);
    if (n_ops >= OP_DEPTH) raise(ST_STACK);
    else begin
      ops[n_ops] = o;
      n_ops++;
    end
  endfunction

  function automatic void apply_top();
    op_e o;
    logic [31:0] a, b, r, ma, mb, q;
    o = ops[n_ops-1];
    n_ops--;
    if (n_vals < 2) begin
      raise(ST_STACK);
      return;
    end
    b = vals[n_vals-1];
    a = vals[n_vals-2];
    n_vals -= 2;
    r = '0;
    case (o)
      OP_ADD: r = a + b;
      OP_SUB: r = a - b;
      OP_MUL: r = a * b;
      default: begin
        if (b == 0) raise(ST_DIV0);
        else begin
          ma = a[31] ? -a : a;
          mb = b[31] ? -b : b;
          q = ma / mb;
          r = (a[31] ^ b[31]) ? -q : q;
        end
      end
    endcase
    push_value(r);
  endfunction

  function automatic void flush_acc();
    if (acc_live) begin
      push_value(acc);
      acc_live = 0;
      acc = '0;
    end
  endfunction

  function automatic void eval_char(char_item_t it);
    logic [7:0] c;
    eval_result_t res;
    c = it.ch;
    if (err == ST_OK) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        acc = acc * 10 + (c - CH_ZERO);
        acc_live = 1;
      end else begin
        flush_acc();
        if (err == ST_OK) begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            while (err == ST_OK && n_ops > 0 && ops[n_ops-1] != OP_LPAR) apply_top();
            if (err == ST_OK) push_operator(c == CH_PLUS ? OP_ADD : OP_SUB);
          end else if (c == CH_STAR || c == CH_SLASH) begin
            while (err == ST_OK && n_ops > 0 &&
                   (ops[n_ops-1] == OP_MUL || ops[n_ops-1] == OP_DIV)) apply_top();
            if (err == ST_OK) push_operator(c == CH_STAR ? OP_MUL : OP_DIV);
          end else if (c == CH_LPAR) begin
            push_operator(OP_LPAR);
          end else if (c == CH_RPAR) begin
            forever begin
              if (n_ops == 0) begin
                raise(ST_STACK);
                break;
              end
              if (ops[n_ops-1] == OP_LPAR) begin
                n_ops--;
                break;
              end
              apply_top();
              if (err != ST_OK) break;
            end
          end else begin
            raise(ST_BADCHR);
          end
        end
      end
    end
    if (!it.last) return;
    res.value = '0;
    if (err == ST_OK) begin
      flush_acc();
      while (err == ST_OK && n_ops > 0) begin
        if (ops[n_ops-1] == OP_LPAR) begin
          raise(ST_STACK);
          break;
        end
        apply_top();
      end
      if (err == ST_OK) begin
        if (n_vals == 0) raise(ST_STACK);
        else res.value = vals[n_vals-1];
      end
    end
    if (err != ST_OK) res.value = '0;
    res.status = err;
    expected_results.push_back(res);
    clear_eval();
  endfunction

  function automatic void add(logic [7:0] c, logic l = 0);
    char_item_t it;
    it.ch = c;
    it.last = l;
    pending_chars.push_back(it);
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) add(s[i], i == s.len() - 1);
  endfunction

  function automatic void add_number(int digits);
    for (int i = 0; i < digits; i++) add(8'(CH_ZERO + $urandom_range(0, 9)));
  endfunction

  function automatic void add_operand(int nest);
    if (nest > 0 && $urandom_range(0, 3) == 0) begin
      add(CH_LPAR);
      add_expr(nest - 1);
      add(CH_RPAR);
    end else begin
      add_number($urandom_range(0, 7) == 0 ? $urandom_range(5, 11) : $urandom_range(1, 3));
    end
  endfunction

  function automatic void add_expr(int nest);
    int terms;
    logic [7:0] opch[4];
    opch = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
    terms = $urandom_range(1, 5);
    add_operand(nest);
    for (int i = 1; i < terms; i++) begin
      add(opch[$urandom_range(0, 3)]);
      add_operand(nest);
    end
  endfunction

  function automatic void add_random_expr();
    int n;
    n = pending_chars.size();
    if ($urandom_range(0, 9) < 8) add_expr(3);
    else begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 3))
          0: add(8'($urandom_range(0, 255)));
          1: add(CH_LPAR);
          2: add(CH_RPAR);
          default: add(8'(CH_ZERO + $urandom_range(0, 9)));
        endcase
      end
    end
    if (pending_chars.size() == n) add(CH_ZERO);
    pending_chars[$].last = 1;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  int push_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) eval_char({char_code_i, end_of_expr_i});
      if (push && full) begin
      end else if (push_gap > 0 || drain_wait || pending_chars.size() == 0) begin
        push <= 1'b0;
        if (push_gap > 0) push_gap <= push_gap - 1;
      end else begin
        char_item_t it;
        it = pending_chars.pop_front();
        push <= 1'b1;
        char_code_i <= it.ch;
        end_of_expr_i <= it.last;
        push_gap <= gap_len();
      end
    end
  end

  int pop_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        eval_result_t e;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result value %0d status %0d", $time, value_o, status_o);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (value_o !== e.value)
            $display("%0t: value expected %0d actual %0d", $time, $signed(e.value), value_o);
          if (status_o !== e.status)
            $display("%0t: status expected %0d actual %0d", $time, e.status, status_o);
          if (value_o !== e.value || status_o !== e.status) errors++;
        end
      end
      if (hold_pop > 0) begin
        hold_pop <= hold_pop - 1;
        pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap <= pop_gap - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        pop_gap <= gap_len();
      end
    end
  end

  initial begin
    clear_eval();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    add_str("0");
    add_str("4294967295");
    add_str("2147483647+1");
    add_str("12*34-5/2");
    add_str("(1+2)*3");
    add_str("7/0");
    add_str("0-7/2");
    add_str("0-2147483648/(0-1)");
    add_str("1+");
    add_str("(1");
    add_str("1)");
    add_str("()");
    add_str("1(2)");
    add_str("()5");
    add_str("2 ");
    add_str("*");
    add(8'hFF, 1);
    add(CH_PLUS, 1);
    for (int i = 0; i < 65; i++) add(CH_LPAR);
    add(CH_ZERO, 1);
    for (int i = 0; i < 65; i++) begin
      add(8'(CH_ZERO + 1));
      add(CH_LPAR);
    end
    add(CH_ZERO, 1);
    wait (pending_chars.size() == 0);
    hold_pop = 300;
    while (pending_chars.size() < 1600) add_random_expr();
    wait (pending_chars.size() < 800);
    drain_wait = 1;
    wait (pending_chars.size() == 0 || expected_results.size() == 0);
    wait (expected_results.size() == 0 && !push);
    repeat (5) @(posedge clk_i);
    drain_wait = 0;
    wait (pending_chars.size() == 0 && !push);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end
endmodule
